FILE: rtl/core/bsf_pkg.sv
// Shared types and constants for the BMP stream to framebuffer block.
// No dependencies; the front, queue, back, top level and testbench import this package.
package bsf_pkg;

    // Screen geometry defaults, handed to the top level as parameter defaults
    localparam int DEFAULT_SCREEN_WIDTH  = 800;
    localparam int DEFAULT_SCREEN_HEIGHT = 480;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 19;
    localparam int COLOR_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int ORIGIN_X_W = 10;
    localparam int ORIGIN_Y_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'd1;

    // Header layout
    localparam logic [7:0] SIG_B       = 8'h42;
    localparam logic [7:0] SIG_M       = 8'h4D;
    localparam logic [5:0] POS_SIG0    = 6'd0;
    localparam logic [5:0] POS_SIG1    = 6'd1;
    localparam logic [5:0] POS_WIDTH0  = 6'h12;
    localparam logic [5:0] POS_HEIGHT0 = 6'h16;
    localparam logic [5:0] POS_DEPTH0  = 6'h1C;
    localparam logic [5:0] HEADER_LAST = 6'd53;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_PIXEL     = 2'd0,
        ST_BAD_SIG   = 2'd1,
        ST_BAD_DEPTH = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_PIXELS = 4'b0010,
        PH_PAD    = 4'b0100,
        PH_IDLE   = 4'b1000
    } phase_t;

    // One classified item from the parser: image column, top-down image row
    typedef struct packed {
        status_t     status;
        logic [31:0] column;
        logic [31:0] row;
        logic [31:0] color;
    } entry_t;

endpackage

FILE: rtl/core/bsf_in_if.sv
// Input channel of the BMP stream block: one file byte per item.
// Standalone; no package dependency.
interface bsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       first_byte;

    modport source (output valid, output byte_value, output first_byte, input ready);
    modport sink   (input valid, input byte_value, input first_byte, output ready);
endinterface

FILE: rtl/core/bsf_out_if.sv
// Output channel of the BMP stream block: one framebuffer write or error per item.
// Standalone; no package dependency.
interface bsf_out_if;
    logic        valid;
    logic        ready;
    logic [18:0] fb_address;
    logic [31:0] pixel_color;
    logic [1:0]  status;

    modport source (output valid, output fb_address, output pixel_color, output status,
                    input ready);
    modport sink   (input valid, input fb_address, input pixel_color, input status,
                    output ready);
endinterface

FILE: rtl/core/bsf_front.sv
// Parser front end: walks the BMP header and pixel rows, one byte per item.
// Depends on bsf_pkg and bsf_in_if; pushes classified entries to bsf_queue.
module bsf_front
    import bsf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bsf_in_if.sink       in_ch,
    input  logic         queue_full,
    output logic         push,
    output entry_t       push_entry
);

    phase_t      phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [15:0] bpp_reg, bpp_next;
    logic [31:0] col_reg, col_next;
    logic [31:0] rows_left_reg, rows_left_next;
    logic [31:0] srow_reg, srow_next;
    logic        flip_reg, flip_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  pad_left_reg, pad_left_next;

    phase_t      phase_cur;
    logic [5:0]  pos_cur;
    logic        take;
    logic [7:0]  b;
    logic [2:0]  nbytes;
    logic [1:0]  row_pad;
    logic [3:0]  row_bytes_lo;
    logic [31:0] lane;
    logic [31:0] color;
    logic        depth_ok;
    logic        sig_bad;
    logic [1:0]  pad_dec;

    assign in_ch.ready = !queue_full;
    assign take        = in_ch.valid && in_ch.ready;
    assign b           = in_ch.byte_value;

    // first_byte restarts the parser for this very byte
    assign phase_cur = in_ch.first_byte ? PH_HEADER : phase_reg;
    assign pos_cur   = in_ch.first_byte ? 6'd0 : pos_reg;

    assign nbytes       = {1'b0, bpp_reg[4:3]} | {bpp_reg[5], 2'b00};
    assign row_bytes_lo = nbytes[1:0] * width_reg[1:0];
    assign row_pad      = 2'd0 - row_bytes_lo[1:0];
    assign depth_ok     = (bpp_reg == 16'd8) || (bpp_reg == 16'd16) ||
                          (bpp_reg == 16'd24) || (bpp_reg == 16'd32);
    assign pad_dec      = pad_left_reg - 2'd1;

    always_comb
    begin
        case (idx_reg)
            2'd0:    lane = {24'd0, b};
            2'd1:    lane = {16'd0, b, 8'd0};
            2'd2:    lane = {8'd0, b, 16'd0};
            default: lane = {b, 24'd0};
        endcase
    end

    assign color = acc_reg | lane;

    always_comb
    begin
        phase_next     = phase_cur;
        pos_next       = pos_cur;
        width_next     = width_reg;
        height_next    = height_reg;
        bpp_next       = bpp_reg;
        col_next       = col_reg;
        rows_left_next = rows_left_reg;
        srow_next      = srow_reg;
        flip_next      = flip_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        pad_left_next  = pad_left_reg;
        push           = 1'b0;
        push_entry     = '{status: ST_PIXEL, column: col_reg, row: srow_reg, color: color};
        sig_bad        = 1'b0;

        unique case (phase_cur)
            PH_HEADER:
            begin
                unique case (pos_cur)
                    POS_SIG0:
                    begin
                        acc_next    = {24'd0, b};
                        width_next  = '0;
                        height_next = '0;
                        bpp_next    = '0;
                    end
                    POS_SIG1:
                    begin
                        if (acc_reg != {24'd0, SIG_B} || b != SIG_M)
                        begin
                            sig_bad = 1'b1;
                        end
                        acc_next = '0;
                    end
                    POS_WIDTH0:           width_next[7:0]    = b;
                    POS_WIDTH0 + 6'd1:    width_next[15:8]   = b;
                    POS_WIDTH0 + 6'd2:    width_next[23:16]  = b;
                    POS_WIDTH0 + 6'd3:    width_next[31:24]  = b;
                    POS_HEIGHT0:          height_next[7:0]   = b;
                    POS_HEIGHT0 + 6'd1:   height_next[15:8]  = b;
                    POS_HEIGHT0 + 6'd2:   height_next[23:16] = b;
                    POS_HEIGHT0 + 6'd3:   height_next[31:24] = b;
                    POS_DEPTH0:           bpp_next[7:0]      = b;
                    POS_DEPTH0 + 6'd1:    bpp_next[15:8]     = b;
                    default: ;
                endcase

                if (sig_bad)
                begin
                    phase_next = PH_IDLE;
                    push       = 1'b1;
                    push_entry = '{status: ST_BAD_SIG, column: '0, row: '0, color: '0};
                end
                else if (pos_cur < HEADER_LAST)
                begin
                    pos_next = pos_cur + 6'd1;
                end
                else if (!depth_ok)
                begin
                    phase_next = PH_IDLE;
                    push       = 1'b1;
                    push_entry = '{status: ST_BAD_DEPTH, column: '0, row: '0, color: '0};
                end
                else if (width_reg[31] || width_reg == '0 || height_reg == '0)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next     = PH_PIXELS;
                    col_next       = '0;
                    idx_next       = '0;
                    acc_next       = '0;
                    flip_next      = !height_reg[31];
                    rows_left_next = height_reg[31] ? 32'd0 - height_reg : height_reg;
                    // bottom-up files start at the last screen row of the image
                    srow_next      = height_reg[31] ? 32'd0 : height_reg - 32'd1;
                end
            end

            PH_PIXELS:
            begin
                if ({1'b0, idx_reg} + 3'd1 < nbytes)
                begin
                    idx_next = idx_reg + 2'd1;
                    acc_next = color;
                end
                else
                begin
                    idx_next = '0;
                    acc_next = '0;
                    push     = 1'b1;
                    if (col_reg + 32'd1 == width_reg)
                    begin
                        col_next = '0;
                        if (row_pad != 2'd0)
                        begin
                            pad_left_next = row_pad;
                            phase_next    = PH_PAD;
                        end
                        else if (rows_left_reg == 32'd1)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            rows_left_next = rows_left_reg - 32'd1;
                            srow_next      = flip_reg ? srow_reg - 32'd1 : srow_reg + 32'd1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 32'd1;
                    end
                end
            end

            PH_PAD:
            begin
                pad_left_next = pad_dec;
                if (pad_dec == 2'd0)
                begin
                    if (rows_left_reg == 32'd1)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next     = PH_PIXELS;
                        rows_left_next = rows_left_reg - 32'd1;
                        srow_next      = flip_reg ? srow_reg - 32'd1 : srow_reg + 32'd1;
                    end
                end
            end

            PH_IDLE: ;

            default: ;
        endcase

        if (!take)
        begin
            push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            bpp_reg       <= bpp_next;
            col_reg       <= col_next;
            rows_left_reg <= rows_left_next;
            srow_reg      <= srow_next;
            flip_reg      <= flip_next;
            idx_reg       <= idx_next;
            acc_reg       <= acc_next;
            pad_left_reg  <= pad_left_next;
        end
    end

endmodule

FILE: rtl/core/bsf_queue.sv
// Small FIFO of classified entries between parser front and address back end.
// Depends on bsf_pkg for entry_t and the queue depth.
module bsf_queue
    import bsf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   empty,
    output entry_t head
);

    entry_t            slots_reg [QUEUE_DEPTH];
    logic [QPTR_W:0]   wr_ptr_reg;
    logic [QPTR_W:0]   rd_ptr_reg;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[QPTR_W] != rd_ptr_reg[QPTR_W]) &&
                   (wr_ptr_reg[QPTR_W-1:0] == rd_ptr_reg[QPTR_W-1:0]);
    assign head  = slots_reg[rd_ptr_reg[QPTR_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg[QPTR_W-1:0]] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/bsf_back.sv
// Back end: places entries on screen, drops off-screen pixels, forms the address.
// Depends on bsf_pkg and bsf_out_if; drains bsf_queue.
module bsf_back
    import bsf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEFAULT_SCREEN_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ORIGIN_X_W-1:0] origin_x,
    input  logic [ORIGIN_Y_W-1:0] origin_y,
    input  logic                  queue_empty,
    input  entry_t                head,
    output logic                  pop,
    bsf_out_if.source             out_ch
);

    localparam int SX_W   = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int SY_W   = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int FULL_W = SY_W + $clog2(SCREEN_WIDTH + 1) + 1;

    logic [32:0]        sx_sum;
    logic [32:0]        sy_sum;
    logic               is_pixel;
    logic               keep;
    logic               out_adv;
    logic               s1_adv;
    logic [FULL_W-1:0]  full_addr;

    logic               s1_valid_reg;
    status_t            s1_status_reg;
    logic [SX_W-1:0]    s1_sx_reg;
    logic [SY_W-1:0]    s1_sy_reg;
    logic [31:0]        s1_color_reg;

    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [31:0]        out_color_reg;
    status_t            out_status_reg;

    assign sx_sum   = 33'(origin_x) + 33'(head.column);
    assign sy_sum   = 33'(origin_y) + 33'(head.row);
    assign is_pixel = (head.status == ST_PIXEL);
    assign keep     = !is_pixel ||
                      (sx_sum < 33'(SCREEN_WIDTH) && sy_sum < 33'(SCREEN_HEIGHT));

    assign out_adv = !out_valid_reg || out_ch.ready;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign pop     = !queue_empty && s1_adv;

    // sx and sy are zero for errors, so the address comes out zero too
    assign full_addr = FULL_W'(s1_sy_reg) * FULL_W'(SCREEN_WIDTH) + FULL_W'(s1_sx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= pop && keep;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_status_reg <= head.status;
            s1_sx_reg     <= is_pixel ? sx_sum[SX_W-1:0] : '0;
            s1_sy_reg     <= is_pixel ? sy_sum[SY_W-1:0] : '0;
            s1_color_reg  <= head.color;
        end
        if (out_adv)
        begin
            out_addr_reg   <= ADDR_W'(full_addr);
            out_color_reg  <= s1_color_reg;
            out_status_reg <= s1_status_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.fb_address  = out_addr_reg;
    assign out_ch.pixel_color = out_color_reg;
    assign out_ch.status      = out_status_reg;

endmodule

FILE: rtl/core/bmp_stream_to_framebuffer.sv
// Top level of the BMP stream to framebuffer block: parser, queue, address unit.
// Depends on bsf_pkg, bsf_in_if, bsf_out_if, bsf_front, bsf_queue, bsf_back.

// Takes an uncompressed BMP file one byte per item on in_ch and gives framebuffer
// writes on out_ch (status 0), or a single error item for a bad 'BM' signature
// (status 1) or a depth other than 8/16/24/32 (status 2). Bytes flow at one item
// per cycle: the parser does one counter/field update per byte, so in_ch.ready
// stays high unless the four-entry queue fills because out_ch is stalled. A pixel
// write enters the queue at the edge that accepts its last byte, then passes a
// placement stage and an address stage with the row multiply before it is presented.
// Setting first_byte restarts parsing on that byte. Bottom-up images are flipped;
// negative heights are drawn top-down. Pixels landing outside SCREEN_WIDTH x
// SCREEN_HEIGHT are consumed silently. origin_x/origin_y are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them only while idle, the block does not enforce it.
module bmp_stream_to_framebuffer
    import bsf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEFAULT_SCREEN_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    bsf_in_if.sink                in_ch,
    bsf_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [ORIGIN_X_W-1:0] origin_x_reg;
    logic [ORIGIN_Y_W-1:0] origin_y_reg;

    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   queue_full;
    logic   queue_empty;
    entry_t head;

    // image placement registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X: origin_x_reg <= cfg_wdata[ORIGIN_X_W-1:0];
                CFG_ORIGIN_Y: origin_y_reg <= cfg_wdata[ORIGIN_Y_W-1:0];
                default: ;
            endcase
        end
    end

    // header walk, pixel assembly, row/column tracking
    bsf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // lets the parser run ahead while the output side is stalled
    bsf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .empty      (queue_empty),
        .head       (head)
    );

    // screen placement, clipping, address multiply, output register
    bsf_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .origin_x    (origin_x_reg),
        .origin_y    (origin_y_reg),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for bmp_stream_to_framebuffer: streams BMP files byte by byte
// and checks every framebuffer write and error item against an in-bench parser model.
// Depends on bsf_pkg, bsf_in_if, bsf_out_if and the block's top level.
module testbench;
    import bsf_pkg::*;

    localparam int SCREEN_W     = DEFAULT_SCREEN_WIDTH;
    localparam int SCREEN_H     = DEFAULT_SCREEN_HEIGHT;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;     // further wait once every expected item is out
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off for the back-pressure test
    localparam int RANDOM_BYTES = 250;
    localparam int MAX_REPORTS  = 40;
    localparam int HEADER_BYTES = 54;

    // One framebuffer write or error item as the block should present it
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        status_t            status;
    } fb_write_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bsf_in_if  in_ch();
    bsf_out_if out_ch();

    bmp_stream_to_framebuffer uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Parser model state: a mirror of the block's header/pixel/pad walk
    // ------------------------------------------------------------------
    logic [5:0]  hdr_pos;
    phase_t      parse_state;
    logic [31:0] img_w;
    logic [31:0] img_h;        // signed in the file: negative means top-down rows
    logic [15:0] pix_depth;
    logic [31:0] col_cnt;
    logic [31:0] row_cnt;
    logic [1:0]  pix_idx;
    logic [31:0] pix_acc;
    logic [1:0]  pad_left;
    logic [ORIGIN_X_W-1:0] org_x;
    logic [ORIGIN_Y_W-1:0] org_y;

    fb_write_t   pending_writes[$];   // expected items, oldest first
    logic [7:0]  file_bytes[$];       // file being built by the stimulus tasks

    // Bookkeeping
    int mismatches     = 0;
    int pixel_writes   = 0;
    int error_items    = 0;
    int bytes_sent     = 0;
    int input_stalls   = 0;
    int origin_changes = 0;
    int cycle_count    = 0;

    // Flow control shared by sender and receiver
    bit smooth_flow  = 1'b0;   // sender adds no gaps and receiver draws no random stalls while set
    bit hold_request = 1'b0;   // receiver starts a long hold-off when it sees this
    int hold_left    = 0;
    int stall_left   = 0;

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(16, 40);
    endfunction

    function void restart_parse();
        hdr_pos     = '0;
        parse_state = PH_HEADER;
        img_w       = '0;
        img_h       = '0;
        pix_depth   = '0;
        col_cnt     = '0;
        row_cnt     = '0;
        pix_idx     = '0;
        pix_acc     = '0;
        pad_left    = '0;
    endfunction

    function logic [31:0] rows_in_image();
        return img_h[31] ? -img_h : img_h;
    endfunction

    // End of a row: either the next row or the whole image is done
    function void advance_row();
        row_cnt     = row_cnt + 32'd1;
        parse_state = (row_cnt >= rows_in_image()) ? PH_IDLE : PH_PIXELS;
    endfunction

    function void expect_write(logic [ADDR_W-1:0] addr, logic [COLOR_W-1:0] color,
                               status_t st);
        fb_write_t w;
        w.addr   = addr;
        w.color  = color;
        w.status = st;
        pending_writes.push_back(w);
    endfunction

    // Advance the model by one accepted byte, queueing any item it produces
    function void parse_file_byte(input logic [7:0] b, input logic first);
        int          nbytes;
        logic [31:0] wide_b;
        logic [31:0] srow;
        logic [31:0] color;
        logic [31:0] row_bytes;
        logic [63:0] sx;
        logic [63:0] sy;
        logic [1:0]  pad;
        wide_b = {24'd0, b};
        if (first)
            restart_parse();
        case (parse_state)
            PH_HEADER:
            begin
                if (hdr_pos == POS_SIG1 && (pix_acc != {24'd0, SIG_B} || b != SIG_M))
                begin
                    parse_state = PH_IDLE;
                    expect_write('0, '0, ST_BAD_SIG);
                end
                else
                begin
                    if (hdr_pos == POS_SIG0)
                        pix_acc = wide_b;
                    else if (hdr_pos == POS_SIG1)
                        pix_acc = '0;
                    else if (hdr_pos >= POS_WIDTH0 && hdr_pos < POS_WIDTH0 + 6'd4)
                        img_w |= wide_b << (8 * (hdr_pos - POS_WIDTH0));
                    else if (hdr_pos >= POS_HEIGHT0 && hdr_pos < POS_HEIGHT0 + 6'd4)
                        img_h |= wide_b << (8 * (hdr_pos - POS_HEIGHT0));
                    else if (hdr_pos == POS_DEPTH0 || hdr_pos == POS_DEPTH0 + 6'd1)
                        pix_depth |= 16'(wide_b << (8 * (hdr_pos - POS_DEPTH0)));

                    // Byte 53 closes the header: judge depth, then image size
                    if (hdr_pos < HEADER_LAST)
                        hdr_pos = hdr_pos + 6'd1;
                    else if (pix_depth != 16'd8 && pix_depth != 16'd16 &&
                             pix_depth != 16'd24 && pix_depth != 16'd32)
                    begin
                        parse_state = PH_IDLE;
                        expect_write('0, '0, ST_BAD_DEPTH);
                    end
                    else if (img_w[31] || img_w == 32'd0 || img_h == 32'd0)
                        parse_state = PH_IDLE;
                    else
                    begin
                        parse_state = PH_PIXELS;
                        col_cnt     = '0;
                        row_cnt     = '0;
                        pix_idx     = '0;
                        pix_acc     = '0;
                    end
                end
            end
            PH_PIXELS:
            begin
                nbytes  = int'(pix_depth[5:3]);
                pix_acc |= wide_b << (8 * pix_idx);
                if (int'(pix_idx) + 1 < nbytes)
                    pix_idx = pix_idx + 2'd1;
                else
                begin
                    color   = pix_acc;
                    pix_acc = '0;
                    pix_idx = '0;
                    // bottom-up files are flipped onto the screen
                    srow = img_h[31] ? row_cnt : rows_in_image() - 32'd1 - row_cnt;
                    sx   = 64'(org_x) + 64'(col_cnt);
                    sy   = 64'(org_y) + 64'(srow);
                    if (sx < 64'(SCREEN_W) && sy < 64'(SCREEN_H))
                        expect_write(ADDR_W'(sy * 64'(SCREEN_W) + sx), color, ST_PIXEL);
                    col_cnt = col_cnt + 32'd1;
                    if (col_cnt >= img_w)
                    begin
                        col_cnt   = '0;
                        row_bytes = 32'(nbytes) * img_w;
                        pad       = 2'd0 - row_bytes[1:0];
                        if (pad != 2'd0)
                        begin
                            pad_left    = pad;
                            parse_state = PH_PAD;
                        end
                        else
                            advance_row();
                    end
                end
            end
            PH_PAD:
            begin
                pad_left = pad_left - 2'd1;
                if (pad_left == 2'd0)
                    advance_row();
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task check_write();
        fb_write_t want;
        if (pending_writes.size() == 0)
            report_mismatch("unexpected item, address", 32'(out_ch.fb_address), '0);
        else
        begin
            want = pending_writes.pop_front();
            if (out_ch.status != want.status)
                report_mismatch("status", 32'(out_ch.status), 32'(want.status));
            if (out_ch.fb_address != want.addr)
                report_mismatch("fb_address", 32'(out_ch.fb_address), 32'(want.addr));
            if (out_ch.pixel_color != want.color)
                report_mismatch("pixel_color", out_ch.pixel_color, want.color);
            if (want.status == ST_PIXEL)
                pixel_writes++;
            else
                error_items++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_write();
    end

    // Receiver: random stalls, no stalls in smooth stretches, and one long
    // hold-off on request so the internal queue fills and input stalls.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!smooth_flow)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d items still pending", $time, pending_writes.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one byte; valid stays high into the next item unless a gap is drawn.
    // The model advances at the edge where the byte is taken.
    task send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = smooth_flow ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.byte_value <= b;
        in_ch.first_byte <= first;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            input_stalls++;
            @(posedge clk);
        end
        parse_file_byte(b, first);
        bytes_sent++;
    endtask

    // 54-byte header with random filler around the fields the block reads
    function void build_header(logic [31:0] w, logic [31:0] h, logic [15:0] bpp);
        file_bytes.delete();
        for (int i = 0; i < HEADER_BYTES; i++)
            file_bytes.push_back(8'($urandom));
        file_bytes[POS_SIG0] = SIG_B;
        file_bytes[POS_SIG1] = SIG_M;
        for (int k = 0; k < 4; k++)
        begin
            file_bytes[POS_WIDTH0 + k]  = w[8*k +: 8];
            file_bytes[POS_HEIGHT0 + k] = h[8*k +: 8];
        end
        file_bytes[POS_DEPTH0]     = bpp[7:0];
        file_bytes[POS_DEPTH0 + 1] = bpp[15:8];
    endfunction

    function void add_random_bytes(int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(8'($urandom));
    endfunction

    function void keep_bytes(int n);
        while (file_bytes.size() > n)
            void'(file_bytes.pop_back());
    endfunction

    // Pixel data size including padding of each row to four bytes
    function int pixel_bytes(logic [31:0] w, logic [31:0] h, logic [15:0] bpp);
        int rows;
        int row_len;
        rows    = h[31] ? int'(-h) : int'(h);
        row_len = (int'(w) * int'(bpp / 16'd8) + 3) / 4 * 4;
        return rows * row_len;
    endfunction

    task send_file(input bit mark_first);
        foreach (file_bytes[i])
            send_byte(file_bytes[i], mark_first && i == 0);
    endtask

    task send_image(input logic [31:0] w, input logic [31:0] h, input logic [15:0] bpp,
                    input bit mark_first);
        build_header(w, h, bpp);
        add_random_bytes(pixel_bytes(w, h, bpp));
        send_file(mark_first);
    endtask

    // Quiet the input and wait until every expected item is out
    task settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Registers are only touched with nothing in flight
    task write_origin(input logic [ORIGIN_X_W-1:0] x, input logic [ORIGIN_Y_W-1:0] y);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ORIGIN_X;
        cfg_wdata <= CFG_DATA_W'(x);
        @(negedge clk);
        cfg_index <= CFG_ORIGIN_Y;
        cfg_wdata <= CFG_DATA_W'(y);
        @(negedge clk);
        cfg_we <= 1'b0;
        org_x = x;
        org_y = y;
        origin_changes++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset the parser already expects byte zero, so a file sent
    // without the first-byte flag still draws; origin is at its reset value.
    // Bytes after the last row are ignored.
    task test_unflagged_start();
        send_image(32'd2, 32'd2, 16'd24, 1'b0);
        repeat (3) send_byte(8'($urandom), 1'b0);
    endtask

    logic [15:0] bad_depths[3] = '{16'd12, 16'h0118, 16'hFFFF};

    // Bad signature on either byte, then unsupported depths (including a
    // valid low byte with the high byte set). Each gives one error item and
    // the parser ignores everything until the next flagged byte zero.
    task test_header_errors();
        build_header(32'd2, 32'd2, 16'd24);
        file_bytes[POS_SIG1] = 8'h58;
        keep_bytes(4);
        send_file(1'b1);
        build_header(32'd2, 32'd2, 16'd24);
        file_bytes[POS_SIG0] = SIG_M;
        keep_bytes(3);
        send_file(1'b1);
        send_byte(SIG_B, 1'b0);
        send_byte(SIG_M, 1'b0);
        foreach (bad_depths[i])
        begin
            build_header(32'd1, 32'd1, bad_depths[i]);
            add_random_bytes(4);
            send_file(1'b1);
        end
    endtask

    // Zero width, negative width and zero height draw nothing; a 1x1 8-bit
    // image afterwards (three padding bytes) must still draw.
    task test_empty_images();
        build_header(32'd0, 32'd3, 16'd8);
        add_random_bytes(6);
        send_file(1'b1);
        build_header(32'h8000_0002, 32'd2, 16'd16);
        add_random_bytes(6);
        send_file(1'b1);
        build_header(32'd3, 32'd0, 16'd24);
        add_random_bytes(6);
        send_file(1'b1);
        send_image(32'd1, 32'd1, 16'd8, 1'b1);
    endtask

    // Every depth, with a width of three so the padding differs per depth;
    // odd steps stored bottom-up, even steps top-down.
    task test_depths_and_flip();
        write_origin(10'd5, 9'd7);
        for (int d = 1; d <= 4; d++)
            send_image(32'd3, (d % 2 == 1) ? 32'd2 : -32'd2, 16'(8 * d), 1'b1);
    endtask

    // Origins at the screen corners and edges: off-screen pixels are consumed
    // without an item.
    task test_screen_edges();
        write_origin(10'd799, 9'd479);
        send_image(32'd3, 32'd3, 16'd16, 1'b1);
        write_origin(10'd796, 9'd474);
        send_image(32'd8, -32'd8, 16'd8, 1'b1);
        write_origin(10'd0, 9'd479);
        send_image(32'd4, 32'd2, 16'd32, 1'b1);
    endtask

    // Receiver holds off while the sender streams with no gaps: the queue
    // fills and the input must stall without losing anything.
    task test_backpressure();
        write_origin(10'd100, 9'd200);
        smooth_flow  = 1'b1;
        hold_request = 1'b1;
        send_image(32'd4, 32'd4, 16'd32, 1'b1);
        smooth_flow = 1'b0;
    endtask

    task random_origin();
        case ($urandom_range(5))
            0: write_origin(10'd0, 9'd0);
            1: write_origin(10'd799, 9'd479);
            2: write_origin(10'd799, 9'($urandom_range(479)));
            3: write_origin(10'($urandom_range(799)), 9'd479);
            default: write_origin(10'($urandom_range(799)), 9'($urandom_range(479)));
        endcase
    endtask

    // Mostly well-formed files with random size, depth and content; the rest
    // are files cut short by a restart, loose noise, header errors and empty
    // images.
    task test_random_files();
        int          start;
        int          kind;
        int          files;
        int          rows;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] bpp;
        start = bytes_sent;
        files = 0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            if (files % 6 == 0)
                random_origin();
            smooth_flow = ($urandom_range(4) == 0);
            kind        = $urandom_range(99);
            bpp         = 16'(8 * $urandom_range(1, 4));
            if (kind < 70)
            begin
                if ($urandom_range(9) == 0)
                begin
                    w    = $urandom_range(10, 48);
                    rows = $urandom_range(1, 2);
                end
                else
                begin
                    w    = $urandom_range(1, 9);
                    rows = $urandom_range(1, 6);
                end
                h = $urandom_range(1) ? -32'(rows) : 32'(rows);
                build_header(w, h, bpp);
                add_random_bytes(pixel_bytes(w, h, bpp) + $urandom_range(3));
                send_file(1'b1);
            end
            else if (kind < 80)
            begin
                // any dimensions at all, cut off and restarted by the next file
                build_header($urandom, $urandom, bpp);
                add_random_bytes(40);
                keep_bytes($urandom_range(2, 94));
                send_file(1'b1);
            end
            else if (kind < 88)
            begin
                repeat ($urandom_range(20, 60))
                    send_byte(8'($urandom), $urandom_range(15) == 0);
            end
            else if (kind < 95)
            begin
                if ($urandom_range(1))
                begin
                    build_header(32'd2, 32'd2, bpp);
                    rows = $urandom_range(1);
                    file_bytes[rows] = file_bytes[rows] ^ 8'($urandom_range(1, 255));
                    keep_bytes($urandom_range(2, 60));
                end
                else
                begin
                    bpp = 16'($urandom);
                    if (bpp == 16'd8 || bpp == 16'd16 || bpp == 16'd24 || bpp == 16'd32)
                        bpp = bpp ^ 16'h0100;
                    build_header(32'd2, 32'd2, bpp);
                    add_random_bytes($urandom_range(4));
                end
                send_file(1'b1);
            end
            else
            begin
                case ($urandom_range(2))
                    0: build_header(32'd0, 32'($urandom_range(1, 4)), bpp);
                    1: build_header({1'b1, 31'($urandom)}, 32'd2, bpp);
                    default: build_header(32'($urandom_range(1, 4)), 32'd0, bpp);
                endcase
                add_random_bytes($urandom_range(8));
                send_file(1'b1);
            end
            files++;
        end
        smooth_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.byte_value = '0;
        in_ch.first_byte = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_ORIGIN_X;
        cfg_wdata        = '0;
        org_x            = '0;
        org_y            = '0;
        restart_parse();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_unflagged_start();
        test_header_errors();
        test_empty_images();
        test_depths_and_flip();
        test_screen_edges();
        test_backpressure();
        test_random_files();

        settle();
        $display("Streamed %0d file bytes (%0d input stall cycles); checked %0d pixel writes",
                 bytes_sent, input_stalls, pixel_writes);
        $display("and %0d error items across %0d origin settings, corners included.",
                 error_items, origin_changes);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/bsf_pkg.sv
rtl/core/bsf_in_if.sv
rtl/core/bsf_out_if.sv
rtl/core/bsf_front.sv
rtl/core/bsf_queue.sv
rtl/core/bsf_back.sv
rtl/core/bmp_stream_to_framebuffer.sv
verif/testbench.sv
